// File: hdl/lc3ie_pkg.sv
// Package for the LC-3 execute unit: request codes, status codes, opcodes.
// No dependencies.
package lc3ie_pkg;

  localparam int unsigned AddrBitsDefault = 16;

  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_SETPC = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_RTI  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;
  localparam logic [1:0] ST_TRAP = 2'd3;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_RES  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] FLAG_N = 3'b100;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_P = 3'b001;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture the accepted item
    logic exec;       // compute and commit register/PC/flag effects
    logic mem_rd;     // start a memory read at the computed address
    logic mem_rd_ind; // start a memory read at the last read data
    logic mem_wr;     // write memory
    logic mem_wr_ind; // write memory at the last read data
    logic wb_load;    // write read data to the destination register
  } lc3ie_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [3:0] op;
  } lc3ie_sts_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) return FLAG_Z;
    else if (v[15]) return FLAG_N;
    else return FLAG_P;
  endfunction

endpackage

// File: hdl/lc3ie_if.sv
// Valid/ready channel interfaces for the LC-3 execute unit.
// Depends on nothing but the widths of the item fields.
interface lc3ie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] word;
  logic [15:0] mem_address;
  modport source (output valid, req_type, word, mem_address, input ready);
  modport sink (input valid, req_type, word, mem_address, output ready);
endinterface

interface lc3ie_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_now;
  logic [2:0]  flags;
  logic [15:0] read_data;
  logic [1:0]  status;
  logic [7:0]  trap_vector;
  modport source (output valid, pc_now, flags, read_data, status, trap_vector, input ready);
  modport sink (input valid, pc_now, flags, read_data, status, trap_vector, output ready);
endinterface

// File: hdl/lc3ie_ctrl.sv
// Controller state machine of the LC-3 execute unit.
// Depends on lc3ie_pkg.
module lc3ie_ctrl import lc3ie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  lc3ie_sts_t sts_i,
  output lc3ie_cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ind_q, ind_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    ind_d   = ind_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        case (sts_i.req)
          REQ_EXEC: begin
            cmd_o.exec = 1'b1;
            case (sts_i.op)
              OP_LD, OP_LDR: begin
                cmd_o.mem_rd = 1'b1;
                ind_d = 1'b0;
                state_d = S_RD1;
              end
              OP_LDI, OP_STI: begin
                cmd_o.mem_rd = 1'b1;
                ind_d = 1'b1;
                state_d = S_RD1;
              end
              OP_ST, OP_STR: cmd_o.mem_wr = 1'b1;
              default: ;
            endcase
          end
          REQ_WRITE: cmd_o.mem_wr = 1'b1;
          REQ_READ: begin
            cmd_o.mem_rd = 1'b1;
            ind_d = 1'b0;
            state_d = S_RD1;
          end
          default: cmd_o.exec = 1'b1;
        endcase
      end
      S_RD1: begin
        // Read data is valid now.
        if (ind_q && sts_i.op == OP_STI) begin
          cmd_o.mem_wr_ind = 1'b1;
          state_d = S_OUT;
        end else if (ind_q) begin
          cmd_o.mem_rd_ind = 1'b1;
          state_d = S_RD2;
        end else begin
          state_d = S_WB;
        end
      end
      S_RD2: state_d = S_WB;
      S_WB: begin
        if (sts_i.req == REQ_EXEC) cmd_o.wb_load = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ind_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ind_q   <= ind_d;
    end
  end
endmodule

// File: hdl/lc3ie_dp.sv
// Datapath of the LC-3 execute unit: register file, PC, flags, word memory.
// Depends on lc3ie_pkg.
module lc3ie_dp import lc3ie_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] word_i,
  input  logic [15:0] mem_address_i,
  input  lc3ie_cmd_t  cmd_i,
  output lc3ie_sts_t  sts_o,
  output logic [15:0] pc_now_o,
  output logic [2:0]  flags_o,
  output logic [15:0] read_data_o,
  output logic [1:0]  status_o,
  output logic [7:0]  trap_vector_o
);
  logic [1:0]  req_q;
  logic [15:0] ins_q, addr_in_q;
  logic [15:0] regs_q [8];
  logic [15:0] pc_q, pc_d;
  logic [2:0]  cc_q;
  logic [1:0]  st_q;
  logic [7:0]  vec_q;
  logic [15:0] mem_q [2**ADDR_BITS];
  logic [15:0] rdata_q;
  logic        rd_out_q;

  logic [3:0]  op;
  logic [2:0]  dr, sr;
  logic [15:0] pc1, off9, off6, off11, opnd, sr_val, alu, ea, res;

  assign op     = ins_q[15:12];
  assign dr     = ins_q[11:9];
  assign sr     = ins_q[8:6];
  assign pc1    = pc_q + 16'd1;
  assign off9   = {{7{ins_q[8]}}, ins_q[8:0]};
  assign off6   = {{10{ins_q[5]}}, ins_q[5:0]};
  assign off11  = {{5{ins_q[10]}}, ins_q[10:0]};
  assign sr_val = regs_q[sr];
  assign opnd   = ins_q[5] ? {{11{ins_q[4]}}, ins_q[4:0]} : regs_q[ins_q[2:0]];
  assign sts_o  = '{req: req_q, op: op};

  always_comb begin
    ea = pc1 + off9;
    if (req_q != REQ_EXEC) ea = addr_in_q;
    else if (op == OP_LDR || op == OP_STR) ea = sr_val + off6;
  end

  always_comb begin
    case (op)
      OP_ADD:  alu = sr_val + opnd;
      OP_AND:  alu = sr_val & opnd;
      OP_NOT:  alu = ~sr_val;
      default: alu = pc1 + off9;
    endcase
  end

  // Next PC for an execute or set-PC item.
  always_comb begin
    pc_d = pc1;
    case (op)
      OP_BR:   if ((dr & cc_q) != 3'd0) pc_d = pc1 + off9;
      OP_JSR:  pc_d = ins_q[11] ? pc1 + off11 : sr_val;
      OP_JMP:  pc_d = sr_val;
      default: ;
    endcase
    if (req_q == REQ_SETPC) pc_d = ins_q;
  end

  // Register write data for load completion.
  assign res = rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q     <= req_type_i;
      ins_q     <= word_i;
      addr_in_q <= mem_address_i;
    end
    if (cmd_i.mem_rd) rdata_q <= mem_q[ea[ADDR_BITS-1:0]];
    if (cmd_i.mem_rd_ind) rdata_q <= mem_q[rdata_q[ADDR_BITS-1:0]];
    if (cmd_i.mem_wr)
      mem_q[ea[ADDR_BITS-1:0]] <= (req_q == REQ_EXEC) ? regs_q[dr] : ins_q;
    if (cmd_i.mem_wr_ind) mem_q[rdata_q[ADDR_BITS-1:0]] <= regs_q[dr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
      pc_q     <= '0;
      cc_q     <= FLAG_Z;
      st_q     <= ST_OK;
      vec_q    <= '0;
      rd_out_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        st_q     <= ST_OK;
        vec_q    <= '0;
        rd_out_q <= (req_type_i == REQ_READ);
      end
      if (cmd_i.exec) begin
        pc_q <= pc_d;
        if (req_q != REQ_SETPC) begin
          case (op)
            OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
              regs_q[dr] <= alu;
              cc_q       <= cc_of(alu);
            end
            OP_JSR:  regs_q[7] <= pc1;
            OP_RTI:  st_q <= ST_RTI;
            OP_RES:  st_q <= ST_RES;
            OP_TRAP: begin
              st_q  <= ST_TRAP;
              vec_q <= ins_q[7:0];
            end
            default: ;
          endcase
        end
      end
      if (cmd_i.wb_load) begin
        regs_q[dr] <= res;
        cc_q       <= cc_of(res);
      end
    end
  end

  assign pc_now_o      = pc_q;
  assign flags_o       = cc_q;
  assign read_data_o   = rd_out_q ? rdata_q : 16'd0;
  assign status_o      = st_q;
  assign trap_vector_o = vec_q;
endmodule

// File: hdl/lc3_instruction_execute_top.sv
// Top level of the LC-3 instruction execute unit: controller plus datapath.
// Depends on lc3ie_pkg, lc3ie_if, lc3ie_ctrl and lc3ie_dp.
//
//   channel  dir  payload
//   in_ch    in   req_type, word, mem_address
//   out_ch   out  pc_now, flags, read_data, status, trap_vector
//
// Items go IDLE, EXEC, OUT (ALU, branch, store, set PC); STI adds RD1; LD, LDR
// and memory reads add RD1 and WB; LDI adds RD1, RD2 and WB; the single-port word
// memory with registered read sets these paths. One item is in flight at a time.
// Reset clears registers, PC and flags (Z set); memory is not cleared.
// A stalled result holds until transferred; no input is taken meanwhile.
module lc3_instruction_execute_top import lc3ie_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  lc3ie_in_if.sink    in_ch,
  lc3ie_out_if.source out_ch
);
  lc3ie_cmd_t cmd;
  lc3ie_sts_t sts;

  lc3ie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lc3ie_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (in_ch.req_type),
    .word_i        (in_ch.word),
    .mem_address_i (in_ch.mem_address),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pc_now_o      (out_ch.pc_now),
    .flags_o       (out_ch.flags),
    .read_data_o   (out_ch.read_data),
    .status_o      (out_ch.status),
    .trap_vector_o (out_ch.trap_vector)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(out_ch.flags)) else $error("condition code not one-hot");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mem_rd, cmd.mem_rd_ind, cmd.mem_wr_ind, cmd.wb_load}))
    else $error("conflicting memory commands");
endmodule
